// ===== src/atr_pkg.sv =====
// Shared types and constants of the AT response parser.
package atr_pkg;

  // Size limits of the stored information lines.
  localparam int LINE_SIZE = 64;
  localparam int MAX_LINES = 8;

  // Counter widths that follow from the limits.
  localparam int COL_W = $clog2(LINE_SIZE);
  localparam int LC_W  = $clog2(MAX_LINES + 1);

  // Fixed widths of the result fields.
  localparam int STATUS_W = 2;
  localparam int LINE_W   = 3;
  localparam int COLUMN_W = 6;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ERROR     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SYNTAX    = 2'd3;

  // Configuration register indexes.
  localparam logic REG_ALLOW_BARE_LINES = 1'b0;

  // Parser states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_GOT_CR,
    S_START,
    S_OK_O,
    S_OK_K,
    S_OK_CR,
    S_ERR_E,
    S_ERR_R1,
    S_ERR_R2,
    S_ERR_O,
    S_ERR_R3,
    S_ERR_CR,
    S_PLUS_FIRST,
    S_PLUS_BODY,
    S_PLUS_CR,
    S_PLUS_LF,
    S_BLANK_CR,
    S_FINAL,
    S_BARE,
    S_BARE_CR,
    S_BARE_LF,
    S_BARE_BLANK_CR,
    S_BARE_FINAL
  } parse_state_t;

  // One result item.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                capture_valid;
    logic [7:0]          capture_byte;
    logic [LINE_W-1:0]   line_index;
    logic [COLUMN_W-1:0] column;
    logic                line_end;
    logic                overflow;
  } result_t;

endpackage

// ===== src/at_response_parser.sv =====
// Top level of the AT response parser: config port, input register, parser, output register.
//
// Usage: the byte channel (byte_valid, byte_stall, byte_in) carries one received
// character per item; an item is taken at a clock edge with byte_valid high and
// byte_stall low. Each byte gives exactly one result item on the result channel
// (result_valid, result_stall and the status, capture and line fields), in order.
// Path: a byte is taken into the input register, the parser state machine works on it
// combinationally, and its result is loaded into the output register once the output
// side can take it. Throughput: one byte per cycle while the receiver does not stall,
// set by the single state transition per byte.
// When the receiver stalls, the output register holds its item, the input
// register fills, and byte_stall rises until the result is taken.
// Reset (rst, synchronous) empties both registers, returns the parser to waiting
// for CR with cleared line and column counters, and sets allow_bare_lines to 1.
// The APB port holds allow_bare_lines at byte address 0; pready is always high.
// Write it only while no item is in flight.
module at_response_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  byte_in,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [atr_pkg::STATUS_W-1:0] status,
  output logic        capture_valid,
  output logic [7:0]  capture_byte,
  output logic [atr_pkg::LINE_W-1:0]   line_index,
  output logic [atr_pkg::COLUMN_W-1:0] column,
  output logic        line_end,
  output logic        overflow
);

  logic             allow_bare_lines;
  logic             in_full;
  logic [7:0]       in_byte;
  logic             take;
  logic             fire;
  atr_pkg::result_t core_result;
  atr_pkg::result_t out_result;

  // Configuration register write and read.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      allow_bare_lines <= 1'b1;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == atr_pkg::REG_ALLOW_BARE_LINES) begin
      allow_bare_lines <= pwdata[0];
    end
  end
  assign prdata = (paddr[2] == atr_pkg::REG_ALLOW_BARE_LINES) ?
                  {31'd0, allow_bare_lines} : 32'd0;

  // Input register: a byte moves on to the parser when the output side takes it.
  assign fire       = in_full && take;
  assign byte_stall = in_full && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!byte_stall) begin
      in_full <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall && byte_valid) begin
      in_byte <= byte_in;
    end
  end

  // Parser state machine.
  atr_parse_core u_core (
    .clk              (clk),
    .rst              (rst),
    .fire             (fire),
    .byte_in          (in_byte),
    .allow_bare_lines (allow_bare_lines),
    .result           (core_result)
  );

  // Output register.
  atr_result_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (in_full),
    .load_data    (core_result),
    .result_stall (result_stall),
    .take         (take),
    .result_valid (result_valid),
    .result_data  (out_result)
  );

  assign status        = out_result.status;
  assign capture_valid = out_result.capture_valid;
  assign capture_byte  = out_result.capture_byte;
  assign line_index    = out_result.line_index;
  assign column        = out_result.column;
  assign line_end      = out_result.line_end;
  assign overflow      = out_result.overflow;

endmodule

// ===== src/atr_parse_core.sv =====
// Parser state machine with line and column counters; result is combinational.
module atr_parse_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        byte_in,
  input  logic              allow_bare_lines,
  output atr_pkg::result_t  result
);

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_O    = 8'h4F;
  localparam logic [7:0] CH_K    = 8'h4B;
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_R    = 8'h52;
  localparam logic [7:0] CH_PLUS = 8'h2B;

  localparam logic [atr_pkg::COL_W-1:0] COL_LAST  = atr_pkg::COL_W'(atr_pkg::LINE_SIZE - 1);
  localparam logic [atr_pkg::LC_W-1:0]  LINE_LIM  = atr_pkg::LC_W'(atr_pkg::MAX_LINES);

  atr_pkg::parse_state_t state, state_next;
  logic [atr_pkg::COL_W-1:0] column_count, column_count_next;
  logic [atr_pkg::LC_W-1:0]  line_num, line_num_next;

  logic bare_ok, info_ok;
  logic cap_req, end_req, go_idle;
  logic [atr_pkg::STATUS_W-1:0] status_code;
  logic [atr_pkg::COL_W-1:0] base_col;
  logic [atr_pkg::LC_W-1:0]  base_line;

  // Letters, digits, colon, space and underscore.
  function automatic logic is_bare_char(input logic [7:0] c);
    is_bare_char = (c >= 8'd48 && c <= 8'd57) || (c >= 8'd65 && c <= 8'd90) ||
                   (c >= 8'd97 && c <= 8'd122) || c == 8'd58 || c == 8'd32 ||
                   c == 8'd95;
  endfunction

  // Printable characters from space to '|' (32 to 124) allowed in a plus line.
  function automatic logic is_info_char(input logic [7:0] c);
    is_info_char = (c >= 8'd32 && c <= 8'd124);
  endfunction

  assign bare_ok = is_bare_char(byte_in);
  assign info_ok = is_info_char(byte_in);

  // Next state of the grammar.
  always_comb begin
    state_next = atr_pkg::S_IDLE;
    case (state)
      atr_pkg::S_IDLE: begin
        state_next = (byte_in == CH_CR) ? atr_pkg::S_GOT_CR : atr_pkg::S_IDLE;
      end
      atr_pkg::S_GOT_CR: begin
        if (byte_in == CH_LF) state_next = atr_pkg::S_START;
      end
      atr_pkg::S_START: begin
        if (byte_in == CH_O) state_next = atr_pkg::S_OK_O;
        else if (byte_in == CH_PLUS) state_next = atr_pkg::S_PLUS_FIRST;
        else if (byte_in == CH_E) state_next = atr_pkg::S_ERR_E;
        else if (allow_bare_lines && bare_ok) state_next = atr_pkg::S_BARE;
      end
      atr_pkg::S_OK_O: begin
        if (byte_in == CH_K) state_next = atr_pkg::S_OK_K;
      end
      atr_pkg::S_OK_K: begin
        if (byte_in == CH_CR) state_next = atr_pkg::S_OK_CR;
      end
      atr_pkg::S_ERR_E: begin
        if (byte_in == CH_R) state_next = atr_pkg::S_ERR_R1;
      end
      atr_pkg::S_ERR_R1: begin
        if (byte_in == CH_R) state_next = atr_pkg::S_ERR_R2;
      end
      atr_pkg::S_ERR_R2: begin
        if (byte_in == CH_O) state_next = atr_pkg::S_ERR_O;
      end
      atr_pkg::S_ERR_O: begin
        if (byte_in == CH_R) state_next = atr_pkg::S_ERR_R3;
      end
      atr_pkg::S_ERR_R3: begin
        if (byte_in == CH_CR) state_next = atr_pkg::S_ERR_CR;
      end
      atr_pkg::S_PLUS_FIRST: begin
        if (info_ok) state_next = atr_pkg::S_PLUS_BODY;
      end
      atr_pkg::S_PLUS_BODY: begin
        if (info_ok) state_next = atr_pkg::S_PLUS_BODY;
        else if (byte_in == CH_CR) state_next = atr_pkg::S_PLUS_CR;
      end
      atr_pkg::S_PLUS_CR: begin
        if (byte_in == CH_LF) state_next = atr_pkg::S_PLUS_LF;
      end
      atr_pkg::S_PLUS_LF: begin
        if (byte_in == CH_PLUS) state_next = atr_pkg::S_PLUS_FIRST;
        else if (byte_in == CH_CR) state_next = atr_pkg::S_BLANK_CR;
      end
      atr_pkg::S_BLANK_CR: begin
        if (byte_in == CH_LF) state_next = atr_pkg::S_FINAL;
      end
      atr_pkg::S_FINAL, atr_pkg::S_BARE_FINAL: begin
        if (byte_in == CH_O) state_next = atr_pkg::S_OK_O;
        else if (byte_in == CH_E) state_next = atr_pkg::S_ERR_E;
      end
      atr_pkg::S_BARE: begin
        if (bare_ok) state_next = atr_pkg::S_BARE;
        else if (byte_in == CH_CR) state_next = atr_pkg::S_BARE_CR;
      end
      atr_pkg::S_BARE_CR: begin
        if (byte_in == CH_LF) state_next = atr_pkg::S_BARE_LF;
      end
      atr_pkg::S_BARE_LF: begin
        if (byte_in == CH_CR) state_next = atr_pkg::S_BARE_BLANK_CR;
      end
      atr_pkg::S_BARE_BLANK_CR: begin
        if (byte_in == CH_LF) state_next = atr_pkg::S_BARE_FINAL;
      end
      default: state_next = atr_pkg::S_IDLE;
    endcase
  end

  // Status and requests for capture or line end, per state.
  always_comb begin
    status_code = atr_pkg::ST_NOT_READY;
    cap_req   = 1'b0;
    end_req   = 1'b0;
    go_idle   = 1'b0;
    base_col  = column_count;
    base_line = line_num;
    case (state)
      atr_pkg::S_IDLE: begin
        go_idle = 1'b1;
      end
      atr_pkg::S_START: begin
        if (byte_in == CH_PLUS || (byte_in != CH_O && byte_in != CH_E &&
            allow_bare_lines && bare_ok)) begin
          cap_req   = 1'b1;
          base_col  = '0;
          base_line = '0;
        end else if (byte_in != CH_O && byte_in != CH_E) begin
          status_code = atr_pkg::ST_SYNTAX;
        end
      end
      atr_pkg::S_OK_CR: begin
        go_idle = 1'b1;
        status_code = (byte_in == CH_LF) ? atr_pkg::ST_OK : atr_pkg::ST_SYNTAX;
      end
      atr_pkg::S_ERR_CR: begin
        go_idle = 1'b1;
        status_code = (byte_in == CH_LF) ? atr_pkg::ST_ERROR : atr_pkg::ST_SYNTAX;
      end
      atr_pkg::S_PLUS_FIRST: begin
        if (info_ok) cap_req = 1'b1;
        else status_code = atr_pkg::ST_SYNTAX;
      end
      atr_pkg::S_PLUS_BODY: begin
        if (info_ok) cap_req = 1'b1;
        else if (byte_in == CH_CR) end_req = 1'b1;
        else status_code = atr_pkg::ST_SYNTAX;
      end
      atr_pkg::S_BARE: begin
        if (bare_ok) cap_req = 1'b1;
        else if (byte_in == CH_CR) end_req = 1'b1;
        else status_code = atr_pkg::ST_SYNTAX;
      end
      atr_pkg::S_PLUS_LF: begin
        if (byte_in == CH_PLUS) begin
          // A new plus line; the index stops at the line limit.
          cap_req  = 1'b1;
          base_col = '0;
          if (line_num < LINE_LIM) base_line = line_num + 1'b1;
        end else if (byte_in != CH_CR) begin
          status_code = atr_pkg::ST_SYNTAX;
        end
      end
      default: begin
        // Fixed-character states: any mismatch is a syntax error.
        if (state_next == atr_pkg::S_IDLE) status_code = atr_pkg::ST_SYNTAX;
      end
    endcase
    if (status_code == atr_pkg::ST_SYNTAX) go_idle = 1'b1;
  end

  // Capture and line end fields, and the counter updates.
  always_comb begin
    result.status        = status_code;
    result.capture_valid = 1'b0;
    result.capture_byte  = '0;
    result.line_index    = '0;
    result.column        = '0;
    result.line_end      = 1'b0;
    result.overflow      = 1'b0;
    column_count_next    = base_col;
    line_num_next        = base_line;
    if (cap_req) begin
      if (base_line >= LINE_LIM || base_col >= COL_LAST) begin
        result.overflow = 1'b1;
      end else begin
        result.capture_valid = 1'b1;
        result.capture_byte  = byte_in;
        result.line_index    = atr_pkg::LINE_W'(base_line);
        result.column        = atr_pkg::COLUMN_W'(base_col);
        column_count_next    = base_col + 1'b1;
      end
    end
    if (end_req) begin
      if (base_line >= LINE_LIM) begin
        result.overflow = 1'b1;
      end else begin
        result.line_end   = 1'b1;
        result.line_index = atr_pkg::LINE_W'(base_line);
        result.column     = atr_pkg::COLUMN_W'(base_col);
      end
    end
    if (go_idle) begin
      column_count_next = '0;
      line_num_next     = '0;
    end
  end

  // State and counters advance once per processed item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= atr_pkg::S_IDLE;
      column_count <= '0;
      line_num     <= '0;
    end else if (fire) begin
      state        <= state_next;
      column_count <= column_count_next;
      line_num     <= line_num_next;
    end
  end

endmodule

// ===== src/atr_result_reg.sv =====
// Output register that holds one result item until the receiver takes it.
module atr_result_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load_valid,
  input  atr_pkg::result_t  load_data,
  input  logic              result_stall,
  output logic              take,
  output logic              result_valid,
  output atr_pkg::result_t  result_data
);

  // The register can take a new item when empty or being emptied.
  assign take = !result_valid || !result_stall;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= load_valid;
    end
  end

  // Payload holds while stalled.
  always_ff @(posedge clk) begin
    if (take && load_valid) begin
      result_data <= load_data;
    end
  end

endmodule
